// ===== sv/bplk_pkg.sv =====
// ----------------------------------------------------------------------------
// bplk_pkg
// Shared types and constants of the buffer pool manager.
// ----------------------------------------------------------------------------
package bplk_pkg;

  localparam int FRAMES_DEF = 64;
  localparam int PAGE_W     = 32;
  localparam int TIME_W     = 64;
  localparam int PIN_W      = 16;

  localparam logic [1:0] ACT_FETCH = 2'd0;
  localparam logic [1:0] ACT_UNPIN = 2'd1;
  localparam logic [1:0] ACT_NEW   = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FRAME = 3'd1;
  localparam logic [2:0] ST_NOT_RES  = 3'd2;
  localparam logic [2:0] ST_UNPINNED = 3'd3;
  localparam logic [2:0] ST_PIN_OVF  = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [PAGE_W-1:0] page_id;
    logic              mark_dirty;
    logic [TIME_W-1:0] access_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              hit;
    logic [5:0]        frame_index;
    logic [PAGE_W-1:0] page_id_out;
    logic [6:0]        pinned_frames;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input item
    logic scan_start; // clear scan state, scan index to 0
    logic scan_step;  // evaluate current frame, advance index
    logic pop;        // free stack supplies the frame (not read by the datapath)
    logic apply;      // perform the update for the action
    logic respond;    // latch result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current index is the last frame
    logic stack_has;  // free stack not empty
  } stat_t;

endpackage

// ===== sv/bplk_if.sv =====
// ----------------------------------------------------------------------------
// bplk_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface bplk_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/buffer_pool_lru_k_manager.sv =====
// ----------------------------------------------------------------------------
// buffer_pool_lru_k_manager
// Page-frame manager with LRU-2 replacement and a LIFO free stack.
// ----------------------------------------------------------------------------
// One item at a time. An accepted item is latched, then a scan walks every
// frame through the page/time/pin memories (lookup, victim pick with ties to
// the lowest index, pinned count), then an update step, which waits while an
// earlier result is still held, applies the item and registers the result.
// The scan reads each table through a single memory read port.
// A result waits in the output register while the next item may be accepted.
// No clearing pass: state bits reset in flops, a pin count only counts while
// its frame is in use, and the free stack reads its reset order until an
// entry is written.
module buffer_pool_lru_k_manager import bplk_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i,
  bplk_if.sink              in_if,
  bplk_if.source            out_if
);
  cmd_t  cmd;
  stat_t stat;

  bplk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bplk_dp #(.FRAMES(FRAMES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_if.data)
  );
endmodule

// ===== sv/bplk_ctrl.sv =====
// ----------------------------------------------------------------------------
// bplk_ctrl
// Sequencer: accept, scan all frames, update, deliver.
// ----------------------------------------------------------------------------
module bplk_ctrl import bplk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  // a new item may enter while the last result still waits, until apply
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.apply   = 1'b1;
          cmd_o.pop     = stat_i.stack_has;
          cmd_o.respond = 1'b1;
          ovalid_d      = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule

// ===== sv/bplk_dp.sv =====
// ----------------------------------------------------------------------------
// bplk_dp
// Frame tables, free stack, sequential lookup / victim / pin-count scan.
// ----------------------------------------------------------------------------
module bplk_dp import bplk_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i,
  input  in_item_t          in_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output out_item_t         out_o
);
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);
  localparam logic [CW-1:0] FULL = CW'(FRAMES);

  // per-frame state: memories for wide fields and pin counts, flops for
  // control bits. A pin count is only meaningful while its frame is in use.
  logic [PAGE_W-1:0] page_mem  [FRAMES];
  logic [TIME_W-1:0] rec_mem   [FRAMES];
  logic [TIME_W-1:0] old_mem   [FRAMES];
  logic [IW-1:0]     stack_mem [FRAMES];
  logic [PIN_W-1:0]  pin_mem   [FRAMES];
  logic [FRAMES-1:0] use_q, dirty_q, acnt2_q, acnt1_q;
  logic [CW-1:0]     top_q;
  logic [PAGE_W-1:0] next_id_q;

  in_item_t          item_q;
  logic [IW-1:0]     idx_q;
  logic              found_q, vfound_q;
  logic [IW-1:0]     hit_f_q, vic_q;
  logic [TIME_W-1:0] vkey_q;
  logic [CW-1:0]     pinned_q;
  out_item_t         out_q;

  // registered reads at the scan index
  logic [PAGE_W-1:0] page_rd_q;
  logic [TIME_W-1:0] old_rd_q;
  logic [TIME_W-1:0] rec_rd_q;
  logic [PIN_W-1:0]  pin_rd_q;
  logic [IW-1:0]     ev_idx_q;   // index of the registered read
  logic              rd_ok_q;
  logic [IW-1:0]     stack_rd_q;
  // hit frame's pin count and latest access time, caught during the scan
  logic [PIN_W-1:0]  pin_hit_q;
  logic [TIME_W-1:0] rec_hit_q;

  // reset stack contents: frame 0 on top. The stack memory starts in
  // identity-reversed form via the offset below, so no fill pass is needed:
  // entry e below the never-written region holds FRAMES-1-e.
  logic [FRAMES-1:0] stk_wr_q;
  logic [IW-1:0]     stack_val;

  assign out_o = out_q;
  assign stat_o.scan_last = rd_ok_q && (ev_idx_q == LAST);
  assign stat_o.stack_has = (top_q != '0);

  logic [IW-1:0] top_m1;
  assign top_m1 = IW'(top_q - CW'(1));

  assign stack_val = stk_wr_q[top_m1] ? stack_rd_q : IW'(FRAMES - 1) - top_m1;

  // memory reads: one index advances during the scan
  always_ff @(posedge clk_i) begin
    page_rd_q  <= page_mem[idx_q];
    old_rd_q   <= old_mem[idx_q];
    rec_rd_q   <= rec_mem[idx_q];
    pin_rd_q   <= pin_mem[idx_q];
    stack_rd_q <= stack_mem[top_m1];
  end

  logic [TIME_W-1:0] key;
  logic              cand, match;
  always_comb begin
    key   = acnt2_q[ev_idx_q] ? old_rd_q : '1;
    cand  = use_q[ev_idx_q] && (pin_rd_q == '0);
    match = use_q[ev_idx_q] && (page_rd_q == item_q.page_id);
  end

  // chosen frame and action decode
  logic [IW-1:0] tgt;
  logic          have;
  logic          is_fetch_hit, ovf;
  always_comb begin
    is_fetch_hit = (item_q.action == ACT_FETCH) && found_q;
    ovf          = is_fetch_hit && (pin_hit_q == '1);
    tgt          = stat_o.stack_has ? stack_val : vic_q;
    have         = stat_o.stack_has || vfound_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q     <= '0;
      dirty_q   <= '0;
      acnt2_q   <= '0;
      acnt1_q   <= '0;
      top_q     <= FULL;
      next_id_q <= '0;
      idx_q     <= '0;
      ev_idx_q  <= '0;
      rd_ok_q   <= 1'b0;
      found_q   <= 1'b0;
      vfound_q  <= 1'b0;
      hit_f_q   <= '0;
      vic_q     <= '0;
      vkey_q    <= '0;
      pinned_q  <= '0;
      pin_hit_q <= '0;
      rec_hit_q <= '0;
    end else begin
      if (cfg_we_i) next_id_q <= cfg_wdata_i;
      if (cmd_i.scan_start) begin
        idx_q    <= '0;
        rd_ok_q  <= 1'b0;
        found_q  <= 1'b0;
        vfound_q <= 1'b0;
        pinned_q <= '0;
      end
      if (cmd_i.scan_step) begin
        if (idx_q != LAST) idx_q <= idx_q + IW'(1);
        rd_ok_q  <= 1'b1;
        ev_idx_q <= idx_q;
        if (rd_ok_q) begin
          if (match && !found_q) begin
            found_q   <= 1'b1;
            hit_f_q   <= ev_idx_q;
            pin_hit_q <= pin_rd_q;
            rec_hit_q <= rec_rd_q;
          end
          if (cand && (!vfound_q || key < vkey_q)) begin
            vfound_q <= 1'b1;
            vic_q    <= ev_idx_q;
            vkey_q   <= key;
          end
          if (use_q[ev_idx_q] && pin_rd_q != '0) pinned_q <= pinned_q + CW'(1);
        end
        if (stat_o.scan_last) rd_ok_q <= 1'b0;
      end
      if (cmd_i.apply) begin
        case (item_q.action)
          ACT_FETCH: begin
            if (found_q) begin
              if (!ovf) begin
                if (pin_hit_q == '0) pinned_q <= pinned_q + CW'(1);
                acnt1_q[hit_f_q] <= 1'b1;
                acnt2_q[hit_f_q] <= acnt1_q[hit_f_q];
              end
            end else if (have) begin
              if (stat_o.stack_has) top_q <= top_q - CW'(1);
              use_q[tgt]   <= 1'b1;
              dirty_q[tgt] <= 1'b0;
              acnt1_q[tgt] <= 1'b1;
              acnt2_q[tgt] <= 1'b0;
              pinned_q     <= pinned_q + CW'(1);
            end
          end
          ACT_UNPIN: begin
            if (found_q && pin_hit_q != '0) begin
              if (item_q.mark_dirty) dirty_q[hit_f_q] <= 1'b1;
              if (pin_hit_q == PIN_W'(1)) begin
                pinned_q <= pinned_q - CW'(1);
                if (!dirty_q[hit_f_q] && !item_q.mark_dirty) begin
                  use_q[hit_f_q]   <= 1'b0;
                  acnt1_q[hit_f_q] <= 1'b0;
                  acnt2_q[hit_f_q] <= 1'b0;
                  if (top_q < FULL) top_q <= top_q + CW'(1);
                end
              end
            end
          end
          ACT_NEW: begin
            if (have) begin
              if (stat_o.stack_has) top_q <= top_q - CW'(1);
              next_id_q    <= next_id_q + PAGE_W'(1);
              use_q[tgt]   <= 1'b1;
              dirty_q[tgt] <= 1'b0;
              acnt1_q[tgt] <= 1'b1;
              acnt2_q[tgt] <= 1'b0;
              pinned_q     <= pinned_q + CW'(1);
            end
          end
          default: dirty_q <= '0;
        endcase
      end
    end
  end

  // stack entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stk_wr_q <= '0;
    end else if (cmd_i.apply && item_q.action == ACT_UNPIN && found_q &&
                 pin_hit_q == PIN_W'(1) && !dirty_q[hit_f_q] &&
                 !item_q.mark_dirty && top_q < FULL) begin
      stk_wr_q[top_q[IW-1:0]] <= 1'b1;
    end
  end

  // item latch, time, page and pin memories, stack writes, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.apply) begin
      case (item_q.action)
        ACT_FETCH: begin
          if (found_q) begin
            if (!ovf) begin
              pin_mem[hit_f_q] <= pin_hit_q + PIN_W'(1);
              old_mem[hit_f_q] <= rec_hit_q;
              rec_mem[hit_f_q] <= item_q.access_time;
            end
          end else if (have) begin
            pin_mem[tgt]  <= PIN_W'(1);
            page_mem[tgt] <= item_q.page_id;
            old_mem[tgt]  <= '0;
            rec_mem[tgt]  <= item_q.access_time;
          end
        end
        ACT_UNPIN: begin
          if (found_q && pin_hit_q != '0) begin
            pin_mem[hit_f_q] <= pin_hit_q - PIN_W'(1);
            if (pin_hit_q == PIN_W'(1) && !dirty_q[hit_f_q] &&
                !item_q.mark_dirty && top_q < FULL)
              stack_mem[top_q[IW-1:0]] <= hit_f_q;
          end
        end
        ACT_NEW: begin
          if (have) begin
            pin_mem[tgt]  <= PIN_W'(1);
            page_mem[tgt] <= next_id_q;
            old_mem[tgt]  <= '0;
            rec_mem[tgt]  <= item_q.access_time;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.respond) begin
      out_q.hit           <= 1'b0;
      out_q.frame_index   <= '0;
      out_q.page_id_out   <= item_q.page_id;
      out_q.status        <= ST_OK;
      out_q.pinned_frames <= 7'(pinned_q);
      case (item_q.action)
        ACT_FETCH: begin
          if (found_q) begin
            out_q.hit         <= 1'b1;
            out_q.frame_index <= 6'(hit_f_q);
            if (ovf) out_q.status <= ST_PIN_OVF;
            else if (pin_hit_q == '0) out_q.pinned_frames <= 7'(pinned_q + CW'(1));
          end else if (have) begin
            out_q.frame_index   <= 6'(tgt);
            out_q.pinned_frames <= 7'(pinned_q + CW'(1));
          end else out_q.status <= ST_NO_FRAME;
        end
        ACT_UNPIN: begin
          if (!found_q) out_q.status <= ST_NOT_RES;
          else begin
            out_q.frame_index <= 6'(hit_f_q);
            if (pin_hit_q == '0) out_q.status <= ST_UNPINNED;
            else if (pin_hit_q == PIN_W'(1))
              out_q.pinned_frames <= 7'(pinned_q - CW'(1));
          end
        end
        ACT_NEW: begin
          if (have) begin
            out_q.frame_index   <= 6'(tgt);
            out_q.page_id_out   <= next_id_q;
            out_q.pinned_frames <= 7'(pinned_q + CW'(1));
          end else begin
            out_q.status      <= ST_NO_FRAME;
            out_q.page_id_out <= '1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sim/bplk_checker.sv =====
// ----------------------------------------------------------------------------
// bplk_checker
// Watches the request and result channels, predicts each result and compares.
// ----------------------------------------------------------------------------
module bplk_checker import bplk_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PAGE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_data_i,
  output int                errors_o,
  output int                pending_o,
  output int                results_o
);

  // mirrored pool state
  logic [PAGE_W-1:0] pool_page  [FRAMES];
  logic              pool_used  [FRAMES];
  logic [PIN_W-1:0]  pool_pins  [FRAMES];
  logic              pool_dirty [FRAMES];
  logic [TIME_W-1:0] pool_t1    [FRAMES];
  logic [TIME_W-1:0] pool_t2    [FRAMES];
  logic [1:0]        pool_hits  [FRAMES];
  int                spare_frames [$];
  logic [PAGE_W-1:0] id_counter;
  out_item_t         expected_results [$];

  assign pending_o = expected_results.size();

  function automatic void wipe_frame(int f);
    pool_used[f] = 0; pool_pins[f] = '0; pool_dirty[f] = 0;
    pool_t1[f] = '0; pool_t2[f] = '0; pool_hits[f] = '0;
  endfunction

  function automatic void touch_frame(int f, logic [TIME_W-1:0] t);
    pool_t2[f] = pool_t1[f];
    pool_t1[f] = t;
    if (pool_hits[f] < 2) pool_hits[f]++;
  endfunction

  function automatic int lookup_page(logic [PAGE_W-1:0] pid);
    for (int f = 0; f < FRAMES; f++)
      if (pool_used[f] && pool_page[f] == pid) return f;
    return -1;
  endfunction

  // free stack first, else LRU-2 victim (lowest index on ties)
  function automatic int grab_frame();
    int best;
    logic [TIME_W-1:0] key, best_key;
    best = -1;
    best_key = '0;
    if (spare_frames.size() > 0) return spare_frames.pop_back();
    for (int f = 0; f < FRAMES; f++) begin
      if (!pool_used[f] || pool_pins[f] != 0) continue;
      key = (pool_hits[f] == 2) ? pool_t2[f] : '1;
      if (best < 0 || key < best_key) begin
        best = f;
        best_key = key;
      end
    end
    if (best >= 0) wipe_frame(best);
    return best;
  endfunction

  function automatic void install_page(int f, logic [PAGE_W-1:0] pid,
                                       logic [TIME_W-1:0] t);
    pool_used[f] = 1; pool_page[f] = pid; pool_pins[f] = 1; pool_dirty[f] = 0;
    touch_frame(f, t);
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int f, n;
    r = '0;
    r.page_id_out = it.page_id;
    case (it.action)
      ACT_FETCH: begin
        f = lookup_page(it.page_id);
        if (f >= 0) begin
          r.hit = 1;
          r.frame_index = f[5:0];
          if (pool_pins[f] == '1) r.status = ST_PIN_OVF;
          else begin
            pool_pins[f]++;
            touch_frame(f, it.access_time);
          end
        end else begin
          f = grab_frame();
          if (f < 0) r.status = ST_NO_FRAME;
          else begin
            install_page(f, it.page_id, it.access_time);
            r.frame_index = f[5:0];
          end
        end
      end
      ACT_UNPIN: begin
        f = lookup_page(it.page_id);
        if (f < 0) r.status = ST_NOT_RES;
        else begin
          r.frame_index = f[5:0];
          if (pool_pins[f] == 0) r.status = ST_UNPINNED;
          else begin
            if (it.mark_dirty) pool_dirty[f] = 1;
            pool_pins[f]--;
            if (pool_pins[f] == 0 && !pool_dirty[f]) begin
              wipe_frame(f);
              spare_frames.push_back(f);
            end
          end
        end
      end
      ACT_NEW: begin
        f = grab_frame();
        if (f < 0) begin
          r.status = ST_NO_FRAME;
          r.page_id_out = '1;
        end else begin
          r.page_id_out = id_counter;
          id_counter++;
          install_page(f, r.page_id_out, it.access_time);
          r.frame_index = f[5:0];
        end
      end
      default: begin
        for (int g = 0; g < FRAMES; g++) pool_dirty[g] = 0;
      end
    endcase
    n = 0;
    for (int g = 0; g < FRAMES; g++) if (pool_pins[g] != 0) n++;
    r.pinned_frames = n[6:0];
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      for (int f = 0; f < FRAMES; f++) begin
        wipe_frame(f);
        pool_page[f] = '0;
      end
      spare_frames.delete();
      for (int f = FRAMES - 1; f >= 0; f--) spare_frames.push_back(f);
      id_counter = '0;
      expected_results.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) id_counter = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_results.push_back(predict_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (expected_results.size() == 0) begin
          if (errors_o < 10) $display("unexpected result %p", out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_data_i) begin
            if (errors_o < 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_buffer_pool_lru_k_manager.sv =====
// ----------------------------------------------------------------------------
// tb_buffer_pool_lru_k_manager
// Random and directed traffic for the buffer pool manager; the checker next
// to the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_buffer_pool_lru_k_manager;
  import bplk_pkg::*;

  localparam int FRAMES    = FRAMES_DEF;
  localparam int N_RANDOM  = 1950;
  // budget: a scan of every frame per item, plus sender gaps and receiver stalls, times margin
  localparam int MAX_CYCLES = 2_000_000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [PAGE_W-1:0] cfg_wdata_i;
  int                errors, pending, results, cycles;
  int                sent;
  int                n_fetch, n_unpin, n_new, n_flush;

  bplk_if #(in_item_t)  in_if  (clk_i);
  bplk_if #(out_item_t) out_if (clk_i);

  buffer_pool_lru_k_manager #(.FRAMES(FRAMES)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  bplk_checker #(.FRAMES(FRAMES)) i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i (in_if.valid),  .in_ready_i (in_if.ready),  .in_data_i (in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: stall pattern of its own, some stretches always ready
  int stall_mode;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= ($urandom_range(0, 3) != 0);
      default: out_if.ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // one item; gaps are added by the caller
  task automatic send_item(logic [1:0] act, logic [PAGE_W-1:0] pid, logic mark,
                           logic [TIME_W-1:0] t);
    in_if.valid <= 1'b1;
    in_if.data  <= '{action: act, page_id: pid, mark_dirty: mark, access_time: t};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
    case (act)
      ACT_FETCH: n_fetch++;
      ACT_UNPIN: n_unpin++;
      ACT_NEW:   n_new++;
      default:   n_flush++;
    endcase
  endtask

  task automatic idle_cycles(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // block idle before a register write: wait until every result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (FRAMES + 8) @(posedge clk_i);
  endtask

  task automatic write_first_id(logic [PAGE_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  logic [TIME_W-1:0] now;

  function automatic logic [TIME_W-1:0] tick();
    now = now + $urandom_range(1, 40);
    return now;
  endfunction

  initial begin
    logic [PAGE_W-1:0] pid;
    logic [1:0]        act;
    int                burst, r;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    stall_mode = 0;
    cycles = 0;
    sent = 0;
    n_fetch = 0; n_unpin = 0; n_new = 0; n_flush = 0;
    now = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every action, error cases, counter wrap
    write_first_id('1 - 1);
    send_item(ACT_NEW, '0, 1'b0, '0);          // id max-1
    send_item(ACT_NEW, '1, 1'b1, '1 - 1);      // id max, counter wraps next
    send_item(ACT_NEW, 32'h5a5a_5a5a, 1'b0, 64'h1);
    send_item(ACT_FETCH, '1, 1'b0, 64'h10);    // hit
    send_item(ACT_FETCH, 32'hffff_0000, 1'b0, 64'h20); // miss, free frame
    send_item(ACT_UNPIN, 32'h1234_5678, 1'b1, 64'h21); // not resident
    send_item(ACT_UNPIN, '1, 1'b1, 64'h22);
    send_item(ACT_UNPIN, '1, 1'b0, 64'h23);    // dirty, stays resident
    send_item(ACT_UNPIN, '1, 1'b0, 64'h24);    // already unpinned
    send_item(ACT_FLUSH, '0, 1'b1, 64'h25);
    send_item(ACT_UNPIN, 32'h0000_0000, 1'b0, 64'h26); // new id 0, last unpin clean
    send_item(ACT_FETCH, 32'h0000_0000, 1'b0, 64'h27); // reload from free stack
    // pause until everything has come back
    drain();

    // fill every frame, then pressure the victim search and no-frame case
    write_first_id(32'h1000);
    for (int i = 0; i < FRAMES + 2; i++) send_item(ACT_NEW, '0, 1'b0, tick());
    drain();

    // random phases with different start ids, extremes among them
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_first_id(32'h0);
        1: write_first_id('1);
        2: write_first_id($urandom());
        default: write_first_id(32'h8000_0000);
      endcase
      for (int k = 0; k < N_RANDOM / 4; ) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst && k < N_RANDOM / 4; b++, k++) begin
          r = $urandom_range(0, 99);
          act = (r < 45) ? ACT_FETCH : (r < 80) ? ACT_UNPIN : (r < 95) ? ACT_NEW
                                                                         : ACT_FLUSH;
          // mostly ids from a small working set so hits and evictions happen
          if ($urandom_range(0, 9) < 8) pid = $urandom_range(0, 90);
          else pid = $urandom();
          send_item(act, pid, $urandom_range(0, 1),
                    ($urandom_range(0, 49) == 0) ? {$urandom(), $urandom()} : tick());
        end
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 3 * FRAMES));
      end
      drain();
    end

    $display("items sent %0d: fetch %0d, unpin %0d, new %0d, flush %0d", sent,
             n_fetch, n_unpin, n_new, n_flush);
    $display("results checked %0d over six start-id settings", results);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bplk_pkg.sv
sv/bplk_if.sv
sv/bplk_ctrl.sv
sv/bplk_dp.sv
sv/buffer_pool_lru_k_manager.sv
sim/bplk_checker.sv
sim/tb_buffer_pool_lru_k_manager.sv
